### rtl/pma_pkg.sv
`timescale 1ns / 1ps
package pma_pkg;

  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int AXES = 3;

  typedef struct packed {
    logic [63:0] weight;
    logic [31:0] count;
    logic [63:0] density;
    logic [63:0] vx;
    logic [63:0] vy;
    logic [63:0] vz;
    logic [63:0] vx_sq;
    logic [63:0] vy_sq;
    logic [63:0] vz_sq;
    logic [63:0] speed;
  } sums_t;

  typedef struct packed {
    logic        start;
    logic [48:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [24:0] root;
  } sqrt_rsp_t;

  function automatic logic [63:0] add_usat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [63:0] add_ssat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  // saturating combine of split partial products: hi * 2^32 + lo
  function automatic logic [63:0] combine_sat(input logic [47:0] hi, input logic [63:0] lo);
    logic [64:0] s;
    s = {1'b0, hi[31:0], 32'd0} + {1'b0, lo};
    if (hi[47:32] != 16'd0 || s[64]) begin
      return {64{1'b1}};
    end
    return s[63:0];
  endfunction

endpackage

### rtl/particle_moment_accumulator.sv
`timescale 1ns / 1ps
// particle moment accumulator: per-cell, per-species saturating moment sums
// input channel (in_valid / in_stall) carries one transaction per command:
//   accumulate adds one particle, read returns an entry's ten sums,
//   read-and-clear returns them and zeroes the entry, opcode 3 is dropped
// output channel (out_valid / out_stall) carries one transaction per read
// commands are handled one at a time; in_stall is high while one is at work
//   read or read-and-clear: ram read, then the result register once out_free
//   accumulate: the 13-step shared 32x32 multiplier sequence, then the
//     bit-serial square root, the speed product and the write back
//   out of range accumulate and opcode 3: dropped, in_stall stays low
// the sums live in one wide single-port-write ram of CELLS*SPECIES entries
// after reset a clearing pass zeroes the ram, one entry per cycle, across all
// CELLS*SPECIES entries (2048 by default) with in_stall high
// a stalled result sits in the output register; a new command is still
// accepted, and a read waits only if the previous result is not yet taken
module particle_moment_accumulator #(
  parameter int CELLS   = 512,
  parameter int SPECIES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [8:0]          cell_index,
  input  logic [1:0]          species,
  input  logic signed [23:0]  vel_x,
  input  logic signed [23:0]  vel_y,
  input  logic signed [23:0]  vel_z,
  input  logic [31:0]         weight,
  input  logic [31:0]         inv_measure,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         sum_weight,
  output logic [31:0]         sum_count,
  output logic [63:0]         sum_density,
  output logic signed [63:0]  sum_vx,
  output logic signed [63:0]  sum_vy,
  output logic signed [63:0]  sum_vz,
  output logic [63:0]         sum_vx_sq,
  output logic [63:0]         sum_vy_sq,
  output logic [63:0]         sum_vz_sq,
  output logic [63:0]         sum_speed
);
  import pma_pkg::*;

  localparam int DEPTH = CELLS * SPECIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $bits(sums_t);

  // sequencer states
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RESP = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_SPD  = 3'd6;
  localparam logic [2:0] ST_WR   = 3'd7;

  localparam logic [3:0] LAST_STEP = 4'd12;

  logic [2:0]    state;
  logic [3:0]    step;
  logic [AW-1:0] clr_addr;

  // latched command
  logic [1:0]    op;
  logic          hit;
  logic [AW-1:0] entry;
  logic [23:0]   mag [AXES];
  logic [AXES-1:0] neg;
  logic [31:0]   w;
  logic [31:0]   im;

  // product registers
  logic [63:0] dens_p;
  logic [55:0] pv   [AXES];
  logic [47:0] sq   [AXES];
  logic [63:0] sql  [AXES];
  logic [47:0] sqh  [AXES];
  logic [56:0] spd_p;

  logic          accept;
  logic          in_range;
  logic [AW-1:0] in_entry;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;

  sums_t         old_sums;
  sums_t         new_sums;
  logic [SW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  sums_t         wr_data;
  logic          out_free;

  sqrt_req_t     sq_req;
  sqrt_rsp_t     sq_rsp;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign in_range = (32'(cell_index) < CELLS) && (32'(species) < SPECIES);
  assign in_entry = AW'(32'(cell_index) * SPECIES + 32'(species));

  assign old_sums = sums_t'(rd_data);

  pma_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (in_entry),
    .rd_data (rd_data)
  );

  pma_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  // speed squared from the three registered squares
  assign sq_req = '{start: (state == ST_SUM),
                    radicand: 49'(sq[0]) + 49'(sq[1]) + 49'(sq[2])};

  // shared multiplier operand selection
  always_comb begin
    mul_a = w;
    mul_b = im;
    if (state == ST_SPD) begin
      mul_a = 32'(sq_rsp.root);
      mul_b = w;
    end else begin
      case (step)
        4'd1, 4'd2, 4'd3: begin
          mul_a = 32'(mag[2'(step - 4'd1)]);
          mul_b = w;
        end
        4'd4, 4'd5, 4'd6: begin
          mul_a = 32'(mag[2'(step - 4'd4)]);
          mul_b = 32'(mag[2'(step - 4'd4)]);
        end
        4'd7, 4'd8, 4'd9: begin
          mul_a = sq[2'(step - 4'd7)][31:0];
          mul_b = w;
        end
        4'd10, 4'd11, 4'd12: begin
          mul_a = 32'(sq[2'(step - 4'd10)][47:32]);
          mul_b = w;
        end
        default: begin
          mul_a = w;
          mul_b = im;
        end
      endcase
    end
    prod = 64'(mul_a) * 64'(mul_b);
  end

  // updated sums for an accumulate
  always_comb begin
    logic [63:0] pvs [AXES];
    for (int a = 0; a < AXES; a++) begin
      pvs[a] = neg[a] ? (~64'(pv[a]) + 64'd1) : 64'(pv[a]);
    end
    new_sums.weight  = add_usat(old_sums.weight, 64'(w));
    new_sums.count   = (old_sums.count == {32{1'b1}}) ? old_sums.count
                                                      : old_sums.count + 32'd1;
    new_sums.density = add_usat(old_sums.density, {16'd0, dens_p[63:16]});
    new_sums.vx      = add_ssat(old_sums.vx, pvs[0]);
    new_sums.vy      = add_ssat(old_sums.vy, pvs[1]);
    new_sums.vz      = add_ssat(old_sums.vz, pvs[2]);
    new_sums.vx_sq   = add_usat(old_sums.vx_sq, combine_sat(sqh[0], sql[0]));
    new_sums.vy_sq   = add_usat(old_sums.vy_sq, combine_sat(sqh[1], sql[1]));
    new_sums.vz_sq   = add_usat(old_sums.vz_sq, combine_sat(sqh[2], sql[2]));
    new_sums.speed   = add_usat(old_sums.speed, 64'(spd_p));
  end

  // ram write port: clearing pass, read-and-clear, accumulate write back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = entry;
    wr_data = '0;
    case (state)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      ST_RESP: begin
        wr_en = out_free && hit && (op == OP_CLEAR);
      end
      ST_WR: begin
        wr_en   = 1'b1;
        wr_data = new_sums;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // command latch and products
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= opcode;
      hit   <= in_range;
      entry <= in_entry;
      w     <= weight;
      im    <= inv_measure;
      neg   <= {vel_z[23], vel_y[23], vel_x[23]};
      mag[0] <= vel_x[23] ? 24'(-vel_x) : vel_x;
      mag[1] <= vel_y[23] ? 24'(-vel_y) : vel_y;
      mag[2] <= vel_z[23] ? 24'(-vel_z) : vel_z;
    end
    if (state == ST_MUL) begin
      case (step)
        4'd0:                 dens_p <= prod;
        4'd1, 4'd2, 4'd3:     pv[2'(step - 4'd1)] <= prod[55:0];
        4'd4, 4'd5, 4'd6:     sq[2'(step - 4'd4)] <= prod[47:0];
        4'd7, 4'd8, 4'd9:     sql[2'(step - 4'd7)] <= prod;
        4'd10, 4'd11, 4'd12:  sqh[2'(step - 4'd10)] <= prod[47:0];
        default:              dens_p <= dens_p;
      endcase
    end
    if (state == ST_SPD) begin
      spd_p <= prod[56:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      step     <= 4'd0;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == DEPTH - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            step <= 4'd0;
            if (opcode == OP_READ || opcode == OP_CLEAR) begin
              state <= ST_RESP;
            end else if (opcode == OP_ACC && in_range) begin
              state <= ST_MUL;
            end
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_MUL: begin
          step <= step + 4'd1;
          if (step == LAST_STEP) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_rsp.done) begin
            state <= ST_SPD;
          end
        end
        ST_SPD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      sum_weight  <= hit ? old_sums.weight  : 64'd0;
      sum_count   <= hit ? old_sums.count   : 32'd0;
      sum_density <= hit ? old_sums.density : 64'd0;
      sum_vx      <= hit ? old_sums.vx      : 64'd0;
      sum_vy      <= hit ? old_sums.vy      : 64'd0;
      sum_vz      <= hit ? old_sums.vz      : 64'd0;
      sum_vx_sq   <= hit ? old_sums.vx_sq   : 64'd0;
      sum_vy_sq   <= hit ? old_sums.vy_sq   : 64'd0;
      sum_vz_sq   <= hit ? old_sums.vz_sq   : 64'd0;
      sum_speed   <= hit ? old_sums.speed   : 64'd0;
    end
  end

endmodule

### rtl/pma_ram.sv
`timescale 1ns / 1ps
module pma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/pma_isqrt.sv
`timescale 1ns / 1ps
module pma_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  pma_pkg::sqrt_req_t  req,
  output pma_pkg::sqrt_rsp_t  rsp
);
  import pma_pkg::*;

  logic [49:0] xs;
  logic [26:0] rem;
  logic [24:0] root;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;

  logic [28:0] rem_sh;
  logic [28:0] trial;
  logic        take;

  // one result bit per cycle, two radicand bits consumed
  always_comb begin
    rem_sh = {rem, xs[49:48]};
    trial  = {2'b00, root, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd25;
        xs   <= {1'b0, req.radicand};
        rem  <= 27'd0;
        root <= 25'd0;
      end else if (busy) begin
        xs  <= {xs[47:0], 2'b00};
        cnt <= cnt - 5'd1;
        if (take) begin
          rem  <= 27'(rem_sh - trial);
          root <= {root[23:0], 1'b1};
        end else begin
          rem  <= rem_sh[26:0];
          root <= {root[23:0], 1'b0};
        end
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, root: root};

endmodule
